### hw/rtl/sipq_pkg.sv
// Shared types and constants for the sorted insert priority queue.
// No dependencies; imported by the cell and the top level.
package sipq_pkg;

	localparam int SCORE_W = 7;
	localparam int TAG_W   = 16;
	localparam int COUNT_W = 8;
	localparam int STAT_W  = 2;

	localparam logic [SCORE_W-1:0] MAX_SCORE = 7'd100;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic [SCORE_W-1:0] key;
		logic [TAG_W-1:0]   tag;
	} sipq_ctl_t;

endpackage

### hw/rtl/sorted_insert_priority_queue_top.sv
// Top level of the sorted insert priority queue: a row of sipq_cell slots plus
// count, status and an output register. Depends on sipq_pkg and sipq_cell.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall   | action, score, tag
//  out     | output    | out_valid / out_stall | status, removed_score, removed_tag,
//          |           |                       | entry_count
//
// One beat per cycle while in_stall is low: every slot compares its score with the broadcast key and
// shifts toward the tail (insert) or the head (remove) at the same edge, and the
// result appears in the output register in the next cycle.
// Reset (arst_n low) clears the entry count and the output valid; slot contents
// are left as they are and are never read above the count.
// in_stall is high only while a result waits in the output register under
// out_stall; a new beat is taken in the cycle the held result leaves.
module sorted_insert_priority_queue_top import sipq_pkg::*; #(
	parameter int DEPTH    = 128,
	parameter int TAG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [SCORE_W-1:0] score,
	input  logic [TAG_W-1:0]   tag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [SCORE_W-1:0] removed_score,
	output logic [TAG_W-1:0]   removed_tag,
	output logic [COUNT_W-1:0] entry_count
);

	// stored tag width: TAG_BITS, but never wider than the tag port
	localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_d;
	logic               in_acc;
	logic               full;
	logic               empty;
	logic               bad;
	logic [STAT_W-1:0]  stat_d;
	sipq_ctl_t          ctl;

	logic [SCORE_W-1:0] cell_score [DEPTH];
	logic [TW-1:0]      cell_tag   [DEPTH];
	logic               cell_ge    [DEPTH];

	// hold the input while a result waits downstream
	assign in_stall = out_valid && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign bad   = (score > MAX_SCORE);

	// status priority: bad score before full on insert
	always_comb begin
		if (action == ACT_INSERT) begin
			if (bad) begin
				stat_d = ST_BAD;
			end else if (full) begin
				stat_d = ST_FULL;
			end else begin
				stat_d = ST_OK;
			end
		end else begin
			stat_d = empty ? ST_EMPTY : ST_OK;
		end
	end

	always_comb begin
		ctl.ins = in_acc && (action == ACT_INSERT) && (stat_d == ST_OK);
		ctl.rem = in_acc && (action == ACT_REMOVE) && (stat_d == ST_OK);
		ctl.key = score;
		ctl.tag = tag;
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ctl.ins) begin
			cnt_d = cnt_q + CW'(1);
		end else if (ctl.rem) begin
			cnt_d = cnt_q - CW'(1);
		end
	end

	// row of slots, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic               held;
		logic               prev_ge;
		logic [SCORE_W-1:0] prev_score;
		logic [TW-1:0]      prev_tag;
		logic [SCORE_W-1:0] next_score;
		logic [TW-1:0]      next_tag;

		assign held = (CW'(i) < cnt_q);

		if (i == 0) begin : g_head
			assign prev_ge    = 1'b0;
			assign prev_score = cell_score[0];
			assign prev_tag   = cell_tag[0];
		end else begin : g_body
			assign prev_ge    = cell_ge[i-1];
			assign prev_score = cell_score[i-1];
			assign prev_tag   = cell_tag[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_score = cell_score[i];
			assign next_tag   = cell_tag[i];
		end else begin : g_inner
			assign next_score = cell_score[i+1];
			assign next_tag   = cell_tag[i+1];
		end

		sipq_cell #(
			.TW(TW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.held      (held),
			.prev_ge   (prev_ge),
			.prev_score(prev_score),
			.prev_tag  (prev_tag),
			.next_score(next_score),
			.next_tag  (next_tag),
			.score_q   (cell_score[i]),
			.tag_q     (cell_tag[i]),
			.ge        (cell_ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (in_acc) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload: load on every accepted beat, hold otherwise
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status      <= stat_d;
			entry_count <= COUNT_W'(cnt_d);
			if (ctl.rem) begin
				removed_score <= cell_score[0];
				removed_tag   <= TAG_W'(cell_tag[0]);
			end else begin
				removed_score <= '0;
				removed_tag   <= '0;
			end
		end
	end

	// count never exceeds the number of slots
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// a remove on an empty queue reports empty next cycle
	a_empty_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == ACT_REMOVE && empty) |=> (out_valid && status == ST_EMPTY))
		else $error("remove on empty queue not reported");

	// a rejected score leaves the count alone
	a_bad_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == ACT_INSERT && bad) |=> (cnt_q == $past(cnt_q)))
		else $error("bad score changed the count");

	// head slot stays in order with its neighbor
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(2)) |-> (cell_score[0] <= cell_score[1]))
		else $error("head out of order");

endmodule

### hw/rtl/sipq_cell.sv
// One slot of the sorted chain: holds a score and a tag, shifts with its neighbors.
// Depends on sipq_pkg.
module sipq_cell import sipq_pkg::*; #(
	parameter int TW = 16
) (
	input  logic               clk,
	input  sipq_ctl_t          ctl,
	input  logic               held,
	input  logic               prev_ge,
	input  logic [SCORE_W-1:0] prev_score,
	input  logic [TW-1:0]      prev_tag,
	input  logic [SCORE_W-1:0] next_score,
	input  logic [TW-1:0]      next_tag,
	output logic [SCORE_W-1:0] score_q,
	output logic [TW-1:0]      tag_q,
	output logic               ge
);

	assign ge = held && (score_q >= ctl.key);

	always_ff @(posedge clk) begin
		if (ctl.rem) begin
			// advance toward the head
			score_q <= next_score;
			tag_q   <= next_tag;
		end else if (ctl.ins && (!held || ge)) begin
			// take the lower neighbor if it moves up, else the new entry
			if (prev_ge) begin
				score_q <= prev_score;
				tag_q   <= prev_tag;
			end else begin
				score_q <= ctl.key;
				tag_q   <= ctl.tag[TW-1:0];
			end
		end
	end

endmodule
